/* rtl/core/dd_odo_pkg.sv */
// Shared types, constants and the arctangent table for the odometry block.
package dd_odo_pkg;

    // Command and move kind codes
    localparam logic CMD_MOVE = 1'b0;
    localparam logic CMD_HOME = 1'b1;

    localparam logic [1:0] KIND_STRAIGHT   = 2'd0;
    localparam logic [1:0] KIND_SPIN_LEFT  = 2'd1;
    localparam logic [1:0] KIND_SPIN_RIGHT = 2'd2;
    localparam logic [1:0] KIND_NONE       = 2'd3;

    // Datapath widths
    localparam int CORDIC_W  = 56;
    localparam int ANGLE_W   = 34;
    localparam int DIV_NUM_W = 54;
    localparam int DIV_DEN_W = 22;
    localparam int MUL_A_W   = 25;
    localparam int MUL_B_W   = 33;
    localparam int MUL_P_W   = 58;
    localparam int TABLE_LEN = 28;

    // Fixed-point constants
    localparam logic [13:0] WHEELBASE_RESET = 14'd1239;
    localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 56'sd652032874;
    localparam logic [MUL_B_W-1:0] TURN_PER_RAD_Q32 = 33'd683565276;
    localparam logic [MUL_B_W-1:0] TWO_PI_Q24 = 33'd105414357;
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam logic signed [ANGLE_W-1:0] QUARTER_TURN_S = 34'sh0_4000_0000;
    localparam logic signed [ANGLE_W-1:0] HALF_TURN_S = 34'sh0_8000_0000;
    localparam logic signed [34:0] POS_MAX = 35'sd2147483647;
    localparam logic signed [34:0] POS_MIN = -35'sd2147483648;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_SPIN_MUL,
        S_DIV_START,
        S_DIV_WAIT,
        S_TRIG_START,
        S_TRIG_WAIT,
        S_ADV_MUL,
        S_ADV_ADD,
        S_ADV_RND,
        S_ADV_SAT,
        S_VEC_START,
        S_VEC_WAIT,
        S_ARC_M1,
        S_ARC_LO,
        S_ARC_HI,
        S_ARC_SUM,
        S_ARC_OUT,
        S_DONE
    } seq_state_t;

    // Control from the sequencer to the CORDIC unit
    typedef struct packed {
        logic start;
        logic vectoring;
    } cordic_ctl_t;

    // Arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] atan_unit(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/dd_odo_div.sv */
// Restoring divider, one quotient bit per cycle, for the spin angle.
module dd_odo_div
    import dd_odo_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quo
);
    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   rem_diff;
    logic                 fits;

    // Shift in the next numerator bit and trial-subtract the divisor
    always_comb
    begin
        rem_sh   = {rem_reg, num_reg[DIV_NUM_W-1]};
        rem_diff = rem_sh - {1'b0, den_reg};
        fits     = (rem_sh >= {1'b0, den_reg});
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIV_NUM_W-2:0], 1'b0};
            rem_reg <= fits ? rem_diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

/* rtl/core/dd_odo_cordic.sv */
// Iterative CORDIC unit, one micro-rotation per cycle, rotation or vectoring mode.
module dd_odo_cordic
    import dd_odo_pkg::*;
#(
    parameter int STEPS = 20
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cordic_ctl_t                ctl,
    input  logic signed [CORDIC_W-1:0] x0,
    input  logic signed [CORDIC_W-1:0] y0,
    input  logic signed [ANGLE_W-1:0]  z0,
    output logic                       done,
    output logic signed [CORDIC_W-1:0] x_out,
    output logic signed [CORDIC_W-1:0] y_out,
    output logic signed [ANGLE_W-1:0]  z_out
);
    localparam int CNT_W = $clog2(STEPS);

    logic                       busy_reg;
    logic                       done_reg;
    logic                       vec_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic signed [CORDIC_W-1:0] x_reg;
    logic signed [CORDIC_W-1:0] y_reg;
    logic signed [ANGLE_W-1:0]  z_reg;
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    logic signed [ANGLE_W-1:0]  at;
    logic                       dir_pos;

    // One micro-rotation: arithmetic shifts, table angle and direction
    always_comb
    begin
        dx = x_reg >>> cnt_reg;
        dy = y_reg >>> cnt_reg;
        at = signed'(ANGLE_W'(atan_unit(5'(cnt_reg))));
        if (vec_reg)
        begin
            dir_pos = !(!y_reg[CORDIC_W-1] && (y_reg != '0));
        end
        else
        begin
            dir_pos = !z_reg[ANGLE_W-1];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Vector and angle registers
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            vec_reg <= ctl.vectoring;
            x_reg   <= x0;
            y_reg   <= y0;
            z_reg   <= z0;
        end
        else if (busy_reg)
        begin
            if (dir_pos)
            begin
                x_reg <= x_reg - dy;
                y_reg <= y_reg + dx;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + dy;
                y_reg <= y_reg - dx;
                z_reg <= z_reg + at;
            end
        end
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

/* rtl/core/differential_drive_odometry_top.sv */
// Top level of the dead-reckoning odometry block: sequencer, shared multiplier, state.
// A straight move runs the CORDIC unit and then the two position updates; a spin first
// waits for the divider; a home query runs the CORDIC unit in vectoring mode.
// One transaction at a time: a new command is accepted only while the sequencer is idle.
// A finished result waits in the output register while the next transaction is accepted.
// Reset clears position, heading and history, and sets the wheelbase to 1239.
module differential_drive_odometry_top
    import dd_odo_pkg::*;
#(
    parameter int CORDIC_STEPS = 20
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [13:0]        wheelbase,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               command,
    input  logic [1:0]         move_kind,
    input  logic [15:0]        distance,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic               home_valid,
    output logic               turn_left,
    output logic [15:0]        turn_arc
);
    seq_state_t state_reg, state_next;

    // Architectural state
    logic [13:0]        wb_reg;
    logic signed [31:0] xp_reg;
    logic signed [31:0] yp_reg;
    logic [23:0]        head_reg;
    logic [1:0]         last_kind_reg;
    logic [15:0]        last_dist_reg;

    // Transaction registers
    logic               cmd_reg;
    logic [1:0]         kind_reg;
    logic [15:0]        dist_reg;
    logic signed [16:0] step_reg;
    logic signed [16:0] step_next;
    logic               axis_reg;
    logic               flip_reg;
    logic signed [32:0] sin_reg;
    logic signed [32:0] cos_reg;
    logic signed [63:0] total_reg;
    logic [63:0]        mag_reg;
    logic               neg_reg;
    logic               left_reg;
    logic [23:0]        a24_reg;
    logic [37:0]        m1_reg;
    logic [65:0]        acc_reg;
    logic [15:0]        arc_reg;
    logic signed [MUL_P_W-1:0] prod_reg;

    // Output register
    logic               out_valid_reg;
    logic signed [31:0] out_x_reg;
    logic signed [31:0] out_y_reg;
    logic               out_home_reg;
    logic               out_left_reg;
    logic [15:0]        out_arc_reg;

    // Combinational helpers
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic signed [MUL_A_W-1:0] step100;
    logic [MUL_A_W-1:0]        dist100;
    logic [13:0]               wb_eff;
    logic [DIV_NUM_W-1:0]      div_num;
    logic [DIV_DEN_W-1:0]      div_den;
    logic                      div_start;
    logic                      div_done;
    logic [DIV_NUM_W-1:0]      div_quo;
    cordic_ctl_t               cor_ctl;
    logic signed [CORDIC_W-1:0] cor_x0;
    logic signed [CORDIC_W-1:0] cor_y0;
    logic signed [ANGLE_W-1:0]  cor_z0;
    logic                       cor_done;
    logic signed [CORDIC_W-1:0] cor_x;
    logic signed [CORDIC_W-1:0] cor_y;
    logic signed [ANGLE_W-1:0]  cor_z;
    logic signed [ANGLE_W-1:0]  z_raw;
    logic signed [ANGLE_W-1:0]  z_fold;
    logic                       fold_flip;
    logic signed [CORDIC_W-1:0] vx;
    logic signed [CORDIC_W-1:0] vy;
    logic                       v_neg;
    logic [31:0]                angle;
    logic [31:0]                turn_t;
    logic [31:0]                turn_a;
    logic signed [31:0]         pos_sel;
    logic signed [63:0]         total_sum;
    logic [63:0]                mag_abs;
    logic signed [34:0]         rnd_val;
    logic signed [31:0]         sat_val;
    logic [65:0]                acc_sum;
    logic                       cfg_take;
    logic                       in_take;
    logic                       out_take;

    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid && cfg_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_take   = in_valid && in_ready;
    assign out_take  = out_valid_reg && out_ready;

    // Step of the move: difference for consecutive straight moves
    always_comb
    begin
        case (move_kind)
            KIND_STRAIGHT:
            begin
                if (last_kind_reg == KIND_STRAIGHT)
                begin
                    step_next = signed'({1'b0, distance}) - signed'({1'b0, last_dist_reg});
                end
                else
                begin
                    step_next = signed'({1'b0, distance});
                end
            end
            KIND_SPIN_LEFT, KIND_SPIN_RIGHT: step_next = signed'({1'b0, distance});
            default: step_next = '0;
        endcase
    end

    // Scaling by 100 with shifts and adds
    always_comb
    begin
        step100 = (MUL_A_W'(step_reg) <<< 6) + (MUL_A_W'(step_reg) <<< 5)
                + (MUL_A_W'(step_reg) <<< 2);
        dist100 = (MUL_A_W'(dist_reg) << 6) + (MUL_A_W'(dist_reg) << 5)
                + (MUL_A_W'(dist_reg) << 2);
    end

    // Divider operands: rounded quotient of the spin angle
    always_comb
    begin
        wb_eff  = (wb_reg == '0) ? 14'd1 : wb_reg;
        div_den = {wb_eff, 8'b0};
        div_num = DIV_NUM_W'(prod_reg) + DIV_NUM_W'({wb_eff, 7'b0});
    end

    // Shared multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SPIN_MUL:
            begin
                mul_a = signed'(dist100);
                mul_b = signed'(TURN_PER_RAD_Q32);
            end
            S_ADV_MUL:
            begin
                mul_a = step100;
                mul_b = axis_reg ? cos_reg : sin_reg;
            end
            S_ARC_M1:
            begin
                mul_a = signed'({1'b0, a24_reg});
                mul_b = signed'(MUL_B_W'(wb_reg));
            end
            S_ARC_LO:
            begin
                mul_a = signed'(MUL_A_W'(prod_reg[17:0]));
                mul_b = signed'(TWO_PI_Q24);
            end
            S_ARC_HI:
            begin
                mul_a = signed'(MUL_A_W'(m1_reg[37:18]));
                mul_b = signed'(TWO_PI_Q24);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Full-width signed product of the shared multiplier
    assign mul_p = mul_a * mul_b;

    // CORDIC start values: folded heading for sin/cos, position for atan2
    always_comb
    begin
        z_raw     = ANGLE_W'(signed'({head_reg, 8'b0}));
        z_fold    = z_raw;
        fold_flip = 1'b0;
        if (z_raw > QUARTER_TURN_S)
        begin
            z_fold    = z_raw - HALF_TURN_S;
            fold_flip = 1'b1;
        end
        else if (z_raw < -QUARTER_TURN_S)
        begin
            z_fold    = z_raw + HALF_TURN_S;
            fold_flip = 1'b1;
        end
        vx    = CORDIC_W'(xp_reg) <<< 20;
        vy    = CORDIC_W'(yp_reg) <<< 20;
        v_neg = xp_reg[31];
        cor_ctl.start     = (state_reg == S_TRIG_START) || (state_reg == S_VEC_START);
        cor_ctl.vectoring = (state_reg == S_VEC_START);
        if (state_reg == S_VEC_START)
        begin
            cor_x0 = v_neg ? -vx : vx;
            cor_y0 = v_neg ? -vy : vy;
            cor_z0 = v_neg ? signed'(ANGLE_W'(HALF_TURN)) : '0;
        end
        else
        begin
            cor_x0 = GAIN_Q30;
            cor_y0 = '0;
            cor_z0 = z_fold;
        end
    end

    // Turn toward home from the atan2 result
    always_comb
    begin
        angle  = ((xp_reg == '0) && (yp_reg == '0)) ? 32'd0 : cor_z[31:0];
        turn_t = HALF_TURN + {head_reg, 8'b0} - angle;
        turn_a = (turn_t <= HALF_TURN) ? turn_t : (32'd0 - turn_t);
    end

    // Position update arithmetic: sum, magnitude with half added, rounding and saturation
    always_comb
    begin
        pos_sel   = axis_reg ? yp_reg : xp_reg;
        total_sum = (64'(pos_sel) <<< 30) + 64'(prod_reg);
        mag_abs   = (total_reg[63] ? 64'(-total_reg) : 64'(total_reg)) + 64'd536870912;
        rnd_val   = neg_reg ? -signed'({1'b0, mag_reg[63:30]}) : signed'({1'b0, mag_reg[63:30]});
        if (rnd_val > POS_MAX)
        begin
            sat_val = 32'(POS_MAX);
        end
        else if (rnd_val < POS_MIN)
        begin
            sat_val = 32'(POS_MIN);
        end
        else
        begin
            sat_val = 32'(rnd_val);
        end
        acc_sum = acc_reg + (66'(prod_reg) << 18) + 66'h8000_0000_0000;
    end

    assign div_start = (state_reg == S_DIV_START);

    dd_odo_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    dd_odo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cor_ctl),
        .x0    (cor_x0),
        .y0    (cor_y0),
        .z0    (cor_z0),
        .done  (cor_done),
        .x_out (cor_x),
        .y_out (cor_y),
        .z_out (cor_z)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (command == CMD_HOME)
                    begin
                        state_next = S_VEC_START;
                    end
                    else if ((move_kind == KIND_SPIN_LEFT) || (move_kind == KIND_SPIN_RIGHT))
                    begin
                        state_next = S_SPIN_MUL;
                    end
                    else
                    begin
                        state_next = S_TRIG_START;
                    end
                end
            end
            S_SPIN_MUL:   state_next = S_DIV_START;
            S_DIV_START:  state_next = S_DIV_WAIT;
            S_DIV_WAIT:   state_next = div_done ? S_TRIG_START : S_DIV_WAIT;
            S_TRIG_START: state_next = S_TRIG_WAIT;
            S_TRIG_WAIT:  state_next = cor_done ? S_ADV_MUL : S_TRIG_WAIT;
            S_ADV_MUL:    state_next = S_ADV_ADD;
            S_ADV_ADD:    state_next = S_ADV_RND;
            S_ADV_RND:    state_next = S_ADV_SAT;
            S_ADV_SAT:    state_next = axis_reg ? S_DONE : S_ADV_MUL;
            S_VEC_START:  state_next = S_VEC_WAIT;
            S_VEC_WAIT:   state_next = cor_done ? S_ARC_M1 : S_VEC_WAIT;
            S_ARC_M1:     state_next = S_ARC_LO;
            S_ARC_LO:     state_next = S_ARC_HI;
            S_ARC_HI:     state_next = S_ARC_SUM;
            S_ARC_SUM:    state_next = S_ARC_OUT;
            S_ARC_OUT:    state_next = S_DONE;
            S_DONE:       state_next = (!out_valid_reg || out_ready) ? S_IDLE : S_DONE;
            default:      state_next = S_IDLE;
        endcase
    end

    // Sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Block state, configuration and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_reg        <= WHEELBASE_RESET;
            xp_reg        <= '0;
            yp_reg        <= '0;
            head_reg      <= '0;
            last_kind_reg <= KIND_STRAIGHT;
            last_dist_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_take)
            begin
                wb_reg <= wheelbase;
            end
            if (in_take && (command == CMD_MOVE))
            begin
                last_kind_reg <= move_kind;
                last_dist_reg <= distance;
            end
            if ((state_reg == S_DIV_WAIT) && div_done)
            begin
                if (kind_reg == KIND_SPIN_LEFT)
                begin
                    head_reg <= head_reg + div_quo[23:0];
                end
                else
                begin
                    head_reg <= head_reg - div_quo[23:0];
                end
            end
            if (state_reg == S_ADV_SAT)
            begin
                if (axis_reg)
                begin
                    yp_reg <= sat_val;
                end
                else
                begin
                    xp_reg <= sat_val;
                end
            end
            if ((state_reg == S_DONE) && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Axis select for the two position updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg <= 1'b0;
        end
        else if (state_reg == S_TRIG_START)
        begin
            axis_reg <= 1'b0;
        end
        else if (state_reg == S_ADV_SAT)
        begin
            axis_reg <= 1'b1;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        if (in_take)
        begin
            cmd_reg  <= command;
            kind_reg <= move_kind;
            dist_reg <= distance;
            step_reg <= step_next;
        end
        if (state_reg == S_TRIG_START)
        begin
            flip_reg <= fold_flip;
        end
        if ((state_reg == S_TRIG_WAIT) && cor_done)
        begin
            sin_reg <= flip_reg ? -cor_y[32:0] : cor_y[32:0];
            cos_reg <= flip_reg ? -cor_x[32:0] : cor_x[32:0];
        end
        if (state_reg == S_ADV_ADD)
        begin
            total_reg <= total_sum;
        end
        if (state_reg == S_ADV_RND)
        begin
            mag_reg <= mag_abs;
            neg_reg <= total_reg[63];
        end
        if ((state_reg == S_VEC_WAIT) && cor_done)
        begin
            left_reg <= (turn_t > HALF_TURN);
            a24_reg  <= turn_a[31:8];
        end
        if (state_reg == S_ARC_LO)
        begin
            m1_reg <= prod_reg[37:0];
        end
        if (state_reg == S_ARC_HI)
        begin
            acc_reg <= 66'(prod_reg);
        end
        if (state_reg == S_ARC_SUM)
        begin
            acc_reg <= acc_sum;
        end
        if (state_reg == S_ARC_OUT)
        begin
            arc_reg <= (acc_reg[65:48] > 18'd65535) ? 16'hFFFF : acc_reg[63:48];
        end
        if ((state_reg == S_DONE) && (!out_valid_reg || out_ready))
        begin
            out_x_reg    <= xp_reg;
            out_y_reg    <= yp_reg;
            out_home_reg <= cmd_reg;
            out_left_reg <= (cmd_reg == CMD_HOME) ? left_reg : 1'b0;
            out_arc_reg  <= (cmd_reg == CMD_HOME) ? arc_reg : 16'd0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pos_x      = out_x_reg;
    assign pos_y      = out_y_reg;
    assign home_valid = out_home_reg;
    assign turn_left  = out_left_reg;
    assign turn_arc   = out_arc_reg;

    // The divider only finishes while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV_WAIT))
        else $error("divider finished outside its wait state");

    // The CORDIC unit only finishes while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        cor_done |-> ((state_reg == S_TRIG_WAIT) || (state_reg == S_VEC_WAIT)))
        else $error("CORDIC finished outside its wait state");

    // A move transaction never reports turn fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !home_valid) |-> (!turn_left && (turn_arc == 16'd0)))
        else $error("move result carries turn fields");

    // Position changes only in the saturation step of a move
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_ADV_SAT) |=> ($stable(xp_reg) && $stable(yp_reg)))
        else $error("position changed outside an update step");

endmodule
